>>> hw/rtl/sorted_table_predicate_search_macros.svh
// ----------------------------------------------------------------------------
// Sorted table predicate search: assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_PREDICATE_SEARCH_MACROS_SVH
`define SORTED_TABLE_PREDICATE_SEARCH_MACROS_SVH

// same-cycle implication
`define STPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/stps_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table predicate search package
// Command and result word types, comparison codes and sequencer states.
// ----------------------------------------------------------------------------
package stps_pkg;

	localparam int ENTRY_INDEX_W = 10;
	localparam int ENTRY_COUNT_W = 11;
	localparam int KEY_FIELD_W   = 64;

	typedef enum logic {
		OPC_WRITE  = 1'b0,
		OPC_SEARCH = 1'b1
	} stps_opc_t;

	typedef enum logic [2:0] {
		OP_GT = 3'd0,
		OP_GE = 3'd1,
		OP_LT = 3'd2,
		OP_LE = 3'd3,
		OP_EQ = 3'd4,
		OP_NE = 3'd5
	} stps_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_SEARCH,
		ST_EQ
	} stps_state_t;

	typedef struct packed {
		logic                     opcode;
		logic [ENTRY_INDEX_W-1:0] entry_index;
		logic [KEY_FIELD_W-1:0]   entry_key;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic [2:0]               compare_op;
		logic                     from_end;
		logic [KEY_FIELD_W-1:0]   target_key;
	} stps_cmd_t;

	typedef struct packed {
		logic                     found;
		logic [ENTRY_INDEX_W-1:0] match_index;
	} stps_result_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic pred;
	} stps_cmp_t;

endpackage

>>> hw/rtl/stps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/stps_cmp.sv
// ----------------------------------------------------------------------------
// Key comparator
// Shared unsigned compare of a table key against the target, with predicate.
// ----------------------------------------------------------------------------
module stps_cmp import stps_pkg::*; #(
	parameter int KEY_WIDTH = 64
) (
	input  logic [KEY_WIDTH-1:0] key,
	input  logic [KEY_WIDTH-1:0] target,
	input  logic [2:0]           op,
	output stps_cmp_t            res
);

	logic lt;
	logic eq;

	assign lt = key < target;
	assign eq = key == target;

	always_comb begin
		res.lt = lt;
		res.eq = eq;
		case (op)
			OP_GT:   res.pred = !lt && !eq;
			OP_GE:   res.pred = !lt;
			OP_LT:   res.pred = lt;
			OP_LE:   res.pred = lt || eq;
			OP_EQ:   res.pred = eq;
			OP_NE:   res.pred = !eq;
			default: res.pred = 1'b0;
		endcase
	end

endmodule

>>> hw/rtl/sorted_table_predicate_search.sv
// ----------------------------------------------------------------------------
// Sorted table predicate search
// Ascending key table with first/last predicate match by binary search.
// ----------------------------------------------------------------------------
// Command channel: a word on cmd is taken when start is high and busy is low.
// A write word (opcode 0) stores entry_key at entry_index and
// gives no result; busy stays low. A search word (opcode 1) checks the first
// entry (last when from_end) and, if that does not decide, runs a binary
// search over entry_count entries, one table read per cycle through a single
// registered-read RAM port and one shared key comparator.
// Result channel: done is high for one cycle with result valid; the receiver
// cannot stall it. A search with a zero count or an invalid comparison gives
// a miss without any search; one that the edge entry decides ends with that
// entry; otherwise the binary search narrows the bound until the range is
// empty, and for eq the candidate is then read once more to check equality.
// The next word may be given in the cycle done is high.
// Reset clears the sequencer and done; table contents are undefined until
// written.
// ----------------------------------------------------------------------------
module sorted_table_predicate_search import stps_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  stps_cmd_t    cmd,
	output logic         done,
	output stps_result_t result
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	stps_state_t state_q, state_n;

	logic [CNT_W-1:0]     n_q, lo_q, hi_q;
	logic [IDX_W-1:0]     mid_q, idx_q;
	logic [2:0]           op_q;
	logic                 rev_q, incl_q;
	logic [KEY_WIDTH-1:0] t_q;
	logic                 done_q, found_q;
	logic [IDX_W-1:0]     index_q;

	logic                 accept, acc_write, acc_search, trivial;
	logic [CNT_W-1:0]     n_sat;
	logic [IDX_W-1:0]     edge_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [KEY_WIDTH-1:0] rd_data;
	stps_cmp_t            cmp;

	logic                 below, edge_miss, cont, bfound;
	logic [CNT_W-1:0]     lo_upd, hi_upd, lo_cur, hi_cur;
	logic [CNT_W:0]       mid_sum;
	logic [IDX_W-1:0]     mid_n, bidx;

	logic                 emit, emit_found;
	logic [IDX_W-1:0]     emit_idx;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign acc_write  = accept && cmd.opcode == OPC_WRITE;
	assign acc_search = accept && cmd.opcode == OPC_SEARCH;

	assign n_sat = (32'(cmd.entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
		: CNT_W'(cmd.entry_count);
	assign trivial   = n_sat == '0 || cmd.compare_op > OP_NE;
	assign edge_addr = cmd.from_end ? IDX_W'(n_sat - CNT_W'(1)) : '0;

	assign wr_en = acc_write && 32'(cmd.entry_index) < TABLE_DEPTH;

	stps_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(cmd.entry_index)),
		.wdata (KEY_WIDTH'(cmd.entry_key)),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	stps_cmp #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_cmp (
		.key    (rd_data),
		.target (t_q),
		.op     (op_q),
		.res    (cmp)
	);

	// bound search step
	assign below  = incl_q ? (cmp.lt || cmp.eq) : cmp.lt;
	assign lo_upd = below ? CNT_W'(mid_q) + CNT_W'(1) : lo_q;
	assign hi_upd = below ? hi_q : CNT_W'(mid_q);
	assign lo_cur = (state_q == ST_EDGE) ? '0 : lo_upd;
	assign hi_cur = (state_q == ST_EDGE) ? n_q : hi_upd;
	assign cont   = lo_cur < hi_cur;
	assign mid_sum = {1'b0, lo_cur} + {1'b0, hi_cur};
	assign mid_n   = IDX_W'(mid_sum >> 1);
	assign bfound  = rev_q ? (lo_cur != '0) : (lo_cur < n_q);
	assign bidx    = rev_q ? IDX_W'(lo_cur - CNT_W'(1)) : IDX_W'(lo_cur);

	assign edge_miss = rev_q ? (op_q inside {OP_GT, OP_GE}) : (op_q inside {OP_LT, OP_LE});

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_search && !trivial) state_n = ST_EDGE;
			end
			ST_EDGE, ST_SEARCH: begin
				if (state_q == ST_EDGE && (cmp.pred || edge_miss)) begin
					state_n = ST_IDLE;
				end else if (cont) begin
					state_n = ST_SEARCH;
				end else if (op_q == OP_EQ && bfound) begin
					state_n = ST_EQ;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_EQ:   state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr    = '0;
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_idx   = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = edge_addr;
				emit    = acc_search && trivial;
			end
			ST_EDGE, ST_SEARCH: begin
				rd_addr = cont ? mid_n : bidx;
				if (state_q == ST_EDGE && cmp.pred) begin
					emit       = 1'b1;
					emit_found = 1'b1;
					emit_idx   = idx_q;
				end else if (state_q == ST_EDGE && edge_miss) begin
					emit = 1'b1;
				end else if (!cont && !(op_q == OP_EQ && bfound)) begin
					emit       = 1'b1;
					emit_found = bfound;
					emit_idx   = bidx;
				end
			end
			ST_EQ: begin
				emit       = 1'b1;
				emit_found = cmp.eq;
				emit_idx   = idx_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_search) begin
			n_q    <= n_sat;
			op_q   <= cmd.compare_op;
			rev_q  <= cmd.from_end;
			t_q    <= KEY_WIDTH'(cmd.target_key);
			idx_q  <= edge_addr;
			incl_q <= cmd.from_end ? (cmd.compare_op inside {OP_LE, OP_EQ})
				: (cmd.compare_op inside {OP_GT, OP_NE});
		end
		if (state_q == ST_EDGE || state_q == ST_SEARCH) begin
			lo_q  <= lo_cur;
			hi_q  <= hi_cur;
			mid_q <= mid_n;
			if (!cont) idx_q <= bidx;
		end
		if (emit) begin
			found_q <= emit_found;
			index_q <= emit_found ? emit_idx : '0;
		end
	end

	assign done               = done_q;
	assign result.found       = found_q;
	assign result.match_index = ENTRY_INDEX_W'(index_q);

endmodule

>>> hw/rtl/stps_chk.sv
// ----------------------------------------------------------------------------
// Sorted table predicate search checker
// Port-level assertions on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "sorted_table_predicate_search_macros.svh"

module stps_chk import stps_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input stps_cmd_t    cmd,
	input logic         done,
	input stps_result_t result
);

	`STPS_ASSERT_IMP(a_miss_zero, done && !result.found, result.match_index == '0, "miss with nonzero index")
	`STPS_ASSERT_NXT(a_write_silent, start && !busy && cmd.opcode == OPC_WRITE, !done, "result after write word")
	`STPS_ASSERT_NXT(a_search_runs, start && !busy && cmd.opcode == OPC_SEARCH, busy || done, "search word dropped")
	`STPS_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")

endmodule

bind sorted_table_predicate_search stps_chk u_stps_chk (.*);

>>> tb/tb_sorted_table_predicate_search.sv
// ----------------------------------------------------------------------------
// Sorted table predicate search testbench
// Builds key tables with write words, then runs first/last predicate searches
// against a behavioral copy of the table. Directed corner cases come first,
// then random runs of sorted tables (some unsorted or disturbed) with random
// searches, sender bursts and gaps. Each result word is checked field by field
// in order against the predicted one.
// ----------------------------------------------------------------------------
module tb_sorted_table_predicate_search;
	timeunit 1ns;
	timeprecision 1ps;

	import stps_pkg::*;

	localparam int          TABLE_DEPTH = 1024;
	localparam int          MAX_COUNT   = 2047;
	localparam int unsigned ITEM_TARGET = 900;
	localparam int          CMD_W       = $bits(stps_cmd_t);
	localparam logic [2:0]  OP_PREFIX   = 3'd6;
	localparam logic [2:0]  OP_RESERVED = 3'd7;
	localparam logic [63:0] KEY_MAX     = '1;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	stps_cmd_t    cmd = '0;
	logic         busy;
	logic         done;
	stps_result_t result;

	stps_cmd_t    pending_words[$];
	stps_result_t expected_results[$];
	stps_result_t oldest_result;
	logic [63:0]  shadow_keys[TABLE_DEPTH];

	// stimulus-side view of the table, used only to choose counts and targets
	logic [63:0]  gen_keys[TABLE_DEPTH];
	bit           gen_written[TABLE_DEPTH];
	int unsigned  gen_prefix = 0;

	int unsigned  burst_left = 0;
	int unsigned  gap_left = 0;
	int unsigned  mismatch_count = 0;

	sorted_table_predicate_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH(64)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit key_satisfies(logic [2:0] op, logic [63:0] k, logic [63:0] t);
		case (op)
		OP_GT: return k > t;
		OP_GE: return k >= t;
		OP_LT: return k < t;
		OP_LE: return k <= t;
		OP_EQ: return k == t;
		OP_NE: return k != t;
		default: return 1'b0;
		endcase
	endfunction

	// leading entries below t (or at or below t when incl), same probe order as the block
	function automatic int unsigned count_below(int unsigned n, logic [63:0] t, bit incl);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (incl ? (shadow_keys[mid] <= t) : (shadow_keys[mid] < t))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic stps_result_t predict_search(stps_cmd_t w);
		stps_result_t res;
		int unsigned  n;
		int unsigned  last;
		int unsigned  i;
		logic [63:0]  t;
		res = '0;
		n = (w.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : w.entry_count;
		t = w.target_key;
		if (n == 0 || w.compare_op > OP_NE)
			return res;
		last = n - 1;
		if (!w.from_end) begin
			if (key_satisfies(w.compare_op, shadow_keys[0], t)) begin
				res.found = 1'b1;
				return res;
			end
			case (w.compare_op)
			OP_GT, OP_NE: i = count_below(n, t, 1'b1);
			OP_GE, OP_EQ: i = count_below(n, t, 1'b0);
			default: i = n;
			endcase
			if (i < n && (w.compare_op != OP_EQ || shadow_keys[i] == t)) begin
				res.found = 1'b1;
				res.match_index = ENTRY_INDEX_W'(i);
			end
		end else begin
			if (key_satisfies(w.compare_op, shadow_keys[last], t)) begin
				res.found = 1'b1;
				res.match_index = ENTRY_INDEX_W'(last);
				return res;
			end
			case (w.compare_op)
			OP_LT, OP_NE: i = count_below(n, t, 1'b0);
			OP_LE, OP_EQ: i = count_below(n, t, 1'b1);
			default: i = 0;
			endcase
			if (i > 0 && (w.compare_op != OP_EQ || shadow_keys[i - 1] == t)) begin
				res.found = 1'b1;
				res.match_index = ENTRY_INDEX_W'(i - 1);
			end
		end
		return res;
	endfunction

	task automatic commit_word(stps_cmd_t w);
		if (w.opcode == OPC_WRITE)
			shadow_keys[w.entry_index] = w.entry_key;
		else
			expected_results.insert(expected_results.size(), predict_search(w));
	endtask

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// unused fields of each word carry random noise
	task automatic queue_write(int unsigned idx, logic [63:0] k);
		stps_cmd_t w;
		w = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		w.opcode = OPC_WRITE;
		w.entry_index = ENTRY_INDEX_W'(idx);
		w.entry_key = k;
		pending_words.insert(pending_words.size(), w);
		gen_keys[idx] = k;
		gen_written[idx] = 1'b1;
		while (gen_prefix < TABLE_DEPTH && gen_written[gen_prefix])
			gen_prefix++;
	endtask

	task automatic queue_search(int unsigned count, logic [2:0] op, bit from_end,
			logic [63:0] t);
		stps_cmd_t w;
		w = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		w.opcode = OPC_SEARCH;
		w.entry_count = ENTRY_COUNT_W'(count);
		w.compare_op = op;
		w.from_end = from_end;
		w.target_key = t;
		pending_words.insert(pending_words.size(), w);
	endtask

	// ascending keys at 0..n-1 in one of several densities, or plain random keys
	task automatic queue_table_run(int unsigned n);
		int unsigned style;
		int unsigned shift;
		logic [63:0] k;
		logic [63:0] step;
		style = $urandom_range(0, 7);
		shift = $urandom_range(2, 63);
		case (style)
		0, 1, 2: k = 64'($urandom_range(0, 3));
		3, 4:    k = 64'($urandom);
		default: k = rand64() >> $urandom_range(0, 63);
		endcase
		for (int unsigned i = 0; i < n; i++) begin
			if (style == 7) begin
				queue_write(i, rand64());
			end else begin
				queue_write(i, k);
				case (style)
				0, 1, 2: step = 64'($urandom_range(0, 2));
				3, 4:    step = 64'($urandom_range(0, 1000));
				default: step = rand64() >> shift;
				endcase
				k = (k > KEY_MAX - step) ? KEY_MAX : k + step;
			end
		end
	endtask

	task automatic queue_random_search(int unsigned n);
		int unsigned sel;
		int unsigned count;
		int unsigned span;
		bit          from_end;
		logic [2:0]  op;
		logic [63:0] t;
		sel = $urandom_range(0, 9);
		from_end = 1'($urandom_range(0, 1));
		op = ($urandom_range(0, 15) < 2) ? 3'($urandom_range(OP_PREFIX, OP_RESERVED))
			: 3'($urandom_range(OP_GT, OP_NE));
		if (sel == 0) begin
			count = 0;
		end else if (sel == 1) begin
			// saturated count: only the first and last entries are known written
			count = $urandom_range(TABLE_DEPTH, MAX_COUNT);
			if (op <= OP_NE)
				op = from_end ? 3'($urandom_range(OP_GT, OP_GE))
					: 3'($urandom_range(OP_LT, OP_LE));
		end else if (sel == 2) begin
			count = $urandom_range(1, gen_prefix);
		end else begin
			count = $urandom_range(1, n);
		end
		span = (count > gen_prefix) ? gen_prefix : count;
		t = (span == 0) ? rand64() : gen_keys[$urandom_range(0, span - 1)];
		case ($urandom_range(0, 7))
		0: t = '0;
		1: t = KEY_MAX;
		2: t = t - 1;
		3: t = t + 1;
		4: t = rand64();
		default: ;
		endcase
		queue_search(count, op, from_end, t);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				commit_word(cmd);
			if (!(start && busy)) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_words.size() != 0) begin
					start <= 1'b1;
					cmd <= pending_words[0];
					pending_words.delete(0);
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result word with none pending: found=%0b index=%0d",
					result.found, result.match_index));
			end else begin
				oldest_result = expected_results[0];
				expected_results.delete(0);
				if (result.found !== oldest_result.found)
					report_mismatch($sformatf("found %0b, predicted %0b",
						result.found, oldest_result.found));
				if (result.match_index !== oldest_result.match_index)
					report_mismatch($sformatf("match_index %0d, predicted %0d",
						result.match_index, oldest_result.match_index));
			end
		end
	end

	initial begin
		int unsigned n;
		int unsigned room;

		// small ascending table with duplicates and both key extremes
		queue_write(0, 64'd0);
		queue_write(1, 64'd5);
		queue_write(2, 64'd5);
		queue_write(3, 64'd10);
		queue_write(4, 64'd20);
		queue_write(5, 64'd20);
		queue_write(6, 64'h8000_0000_0000_0000);
		queue_write(7, KEY_MAX);
		// last entry, so saturated counts can check the edge from the end
		queue_write(TABLE_DEPTH - 1, KEY_MAX);
		queue_search(0, OP_GT, 1'b0, 64'd0);
		queue_search(8, OP_PREFIX, 1'b0, 64'd5);
		queue_search(8, OP_RESERVED, 1'b1, 64'd5);
		queue_search(8, OP_GT, 1'b0, 64'd5);
		queue_search(8, OP_GE, 1'b0, 64'd20);
		queue_search(8, OP_LT, 1'b0, 64'd0);
		queue_search(8, OP_LE, 1'b0, 64'd0);
		queue_search(8, OP_EQ, 1'b0, 64'd20);
		queue_search(8, OP_EQ, 1'b0, 64'd7);
		queue_search(8, OP_NE, 1'b0, 64'd0);
		queue_search(8, OP_GT, 1'b0, KEY_MAX);
		queue_search(8, OP_GT, 1'b1, KEY_MAX);
		queue_search(8, OP_GE, 1'b1, KEY_MAX);
		queue_search(8, OP_LT, 1'b1, 64'd20);
		queue_search(8, OP_LT, 1'b1, 64'd0);
		queue_search(8, OP_LE, 1'b1, 64'd5);
		queue_search(8, OP_EQ, 1'b1, 64'd5);
		queue_search(8, OP_NE, 1'b1, KEY_MAX);
		queue_search(1, OP_LE, 1'b1, 64'd0);
		queue_search(TABLE_DEPTH, OP_GE, 1'b1, 64'd5);
		queue_search(MAX_COUNT, OP_GT, 1'b1, KEY_MAX);
		queue_search(MAX_COUNT, OP_LT, 1'b0, 64'd0);

		while (pending_words.size() < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
			7, 8:    n = $urandom_range(17, 64);
			9:       n = $urandom_range(65, 256);
			default: n = $urandom_range(1, 16);
			endcase
			room = ITEM_TARGET - pending_words.size();
			if (n > room)
				n = room;
			queue_table_run(n);
			repeat ($urandom_range(6, 16)) begin
				if ($urandom_range(0, 15) == 0)
					queue_write($urandom_range(0, TABLE_DEPTH - 1), rand64());
				queue_random_search(n);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/stps_pkg.sv
hw/rtl/stps_ram.sv
hw/rtl/stps_cmp.sv
hw/rtl/sorted_table_predicate_search.sv
hw/rtl/stps_chk.sv
tb/tb_sorted_table_predicate_search.sv
